>>> rtl/ust_pkg.sv
// Shared types and constants for the unordered set table.
// Used by the top level and its port checker; no dependencies.
package ust_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register word indexes on the APB port
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE_OK    = 2'd0,
    ST_INS_FULL   = 2'd1,
    ST_INS_DUP    = 2'd2,
    ST_DEL_ABSENT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] count_after;
    status_e          status;
  } result_t;

endpackage

>>> rtl/unordered_set_table.sv
// Top level of the unordered set table: sequencer, entry memory, APB register.
// Depends on ust_pkg.
//
// Holds up to DEPTH distinct 32-bit values in a packed, ordered array. Each
// transfer is a lookup, insert or delete; it walks the entries one at a time
// through a single memory read port and one 32-bit comparator, reading and then
// comparing each entry examined. A delete then moves every later entry down one
// place, reading and then writing each entry moved. The result is registered in
// S_DECIDE and copied to the output register in S_DONE, and in_ready_o returns
// once the sequencer is back in S_IDLE.
// The block takes one item at a time;
// in_ready_o is low while an item is in flight. The result sits in an output
// register, so a stalled consumer holds only the last stage, and the next
// item waits there until the previous result is taken. capacity_limit (APB
// address 0) caps the fill; values above DEPTH act as DEPTH. Write it only
// while idle.
module unordered_set_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  op_i,
  input  logic signed [31:0]          value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [4:0]                  position_o,
  output logic [4:0]                  count_after_o,
  output logic [1:0]                  status_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ust_pkg::APB_AW-1:0]  paddr,
  input  logic [ust_pkg::APB_DW-1:0]  pwdata,
  output logic [ust_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import ust_pkg::*;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [VAL_W-1:0]   value_q, value_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               found_q, found_d;
  logic [CNT_W-1:0]   count_q, count_d;
  result_t            res_q, res_d;
  result_t            out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [CAP_W-1:0]   cap_q;

  logic [VAL_W-1:0]   mem [DEPTH];
  logic [VAL_W-1:0]   rd_data_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [VAL_W-1:0]   wr_data;

  logic               in_xfer;
  logic               out_load;
  logic               match;
  logic [CNT_W-1:0]   idx_next;
  logic               full;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign match      = (rd_data_q == value_q);
  assign idx_next   = {1'b0, idx_q} + CNT_W'(1);
  // capacity above DEPTH behaves as DEPTH
  assign full       = (32'(cap_q) > 32'(DEPTH)) ? (32'(count_q) >= 32'(DEPTH))
                                                : (32'(count_q) >= 32'(cap_q));

  // APB register
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DW'(cap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (count_q == '0) ? S_DECIDE : S_READ;
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (match || idx_next == count_q) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_READ;
        end
      end
      S_DECIDE: begin
        if (op_q == OP_DELETE && found_q && idx_next < count_q) begin
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: begin
        // count already decremented: stop once the last live slot is written
        state_d = (idx_next < count_q) ? S_SHIFT_RD : S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_d        = op_q;
    value_d     = value_q;
    idx_d       = idx_q;
    found_d     = found_q;
    count_d     = count_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_addr     = idx_q;
    mem_we      = 1'b0;
    wr_addr     = idx_q;
    wr_data     = rd_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d    = op_e'(op_i);
          value_d = value_i;
          idx_d   = '0;
          found_d = 1'b0;
        end
      end
      S_READ: rd_addr = idx_q;
      S_CMP: begin
        if (match) begin
          found_d = 1'b1;
        end else if (idx_next != count_q) begin
          idx_d = idx_next[IDX_W-1:0];
        end
      end
      S_DECIDE: begin
        res_d.found       = found_q;
        res_d.position    = found_q ? {1'b0, idx_q} : count_q;
        res_d.count_after = count_q;
        res_d.status      = ST_DONE_OK;
        unique case (op_q)
          OP_INSERT: begin
            if (found_q) begin
              res_d.status = ST_INS_DUP;
            end else if (full) begin
              res_d.status = ST_INS_FULL;
            end else begin
              mem_we            = 1'b1;
              wr_addr           = count_q[IDX_W-1:0];
              wr_data           = value_q;
              count_d           = count_q + CNT_W'(1);
              res_d.count_after = count_q + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            if (!found_q) begin
              res_d.status = ST_DEL_ABSENT;
            end else begin
              count_d           = count_q - CNT_W'(1);
              res_d.count_after = count_q - CNT_W'(1);
            end
          end
          OP_LOOKUP, OP_SPARE: ;
          default: ;
        endcase
      end
      S_SHIFT_RD: rd_addr = idx_next[IDX_W-1:0];
      S_SHIFT_WR: begin
        mem_we  = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data_q;
        idx_d   = idx_next[IDX_W-1:0];
      end
      S_DONE: begin
        if (out_load) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    value_q <= value_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign position_o    = 5'(out_q.position);
  assign count_after_o = 5'(out_q.count_after);
  assign status_o      = out_q.status;

endmodule

>>> rtl/ust_checker.sv
// Port-level checker for the unordered set table, bound to the top level.
// Depends on ust_pkg.
module ust_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [1:0]                  op_i,
  input logic signed [31:0]          value_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        found_o,
  input logic [4:0]                  position_o,
  input logic [4:0]                  count_after_o,
  input logic [1:0]                  status_o
);
  import ust_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_o)
      && $stable(count_after_o) && $stable(status_o) && $stable(found_o))
    else $error("result changed while stalled");

  // waiting input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(op_i) && $stable(value_i))
    else $error("input payload changed while waiting");

  // one item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  a_status_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o ? (status_o == ST_DONE_OK || status_o == ST_INS_DUP)
                             : (status_o != ST_INS_DUP)))
    else $error("status disagrees with found");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(count_after_o) <= DEPTH && 32'(position_o) <= DEPTH)
    else $error("count or position beyond depth");

endmodule

bind unordered_set_table ust_checker u_ust_checker (.*);
